/* rtl/boundary_tag_heap_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the boundary tag heap allocator
// Clocked, reset-qualified wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication checked on every rising edge out of reset
`define BTAU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising edge out of reset
`define BTAU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bthalloc_pkg.sv */
// ----------------------------------------------------------------------------
// Boundary tag heap allocator package
// Heap geometry, tag and position types, sequencer states and tag helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bthalloc_pkg;

    localparam int HEAP_BYTES = 8192;
    localparam int WORD_COUNT = HEAP_BYTES / 8;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int TAG_W      = $clog2(HEAP_BYTES) + 1;

    localparam int REQ_W      = 13;
    localparam int OFF_W      = 13;
    localparam int IN_DATA_W  = ((REQ_W + OFF_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((OFF_W + 7) / 8) * 8;

    // byte positions and sizes, wide enough for at + size and a rounded request
    localparam int POS_W = ((TAG_W > REQ_W + 1) ? TAG_W : REQ_W + 1) + 1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [POS_W-1:0]  pos_t;

    localparam pos_t HEAP_P    = POS_W'(HEAP_BYTES);
    localparam pos_t TAG_P     = POS_W'(16);
    localparam pos_t WORD_P    = POS_W'(8);
    localparam pos_t ALIGN_P   = POS_W'(7);
    localparam addr_t LAST_A   = ADDR_W'(WORD_COUNT - 1);
    localparam tag_t HEAP_TAG  = TAG_W'(HEAP_BYTES);
    localparam tag_t USED_TAG  = TAG_W'(1);

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_FREE   = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_CHK,
        ST_A_WE2,
        ST_A_WS2,
        ST_A_WS3,
        ST_A_WS4,
        ST_F_HDR,
        ST_F_FTR,
        ST_F_W2,
        ST_F_PRD,
        ST_F_PCHK,
        ST_F_PCMP,
        ST_F_PW2,
        ST_F_PW3,
        ST_F_PW4,
        ST_F_NRD,
        ST_F_NCHK,
        ST_F_NW2,
        ST_F_NW3,
        ST_F_NW4,
        ST_RESP
    } state_t;

    function automatic addr_t word_of(input pos_t p);
        return p[ADDR_W+2:3];
    endfunction

    function automatic tag_t tag_of(input pos_t p);
        return p[TAG_W-1:0];
    endfunction

    // block of size sz at byte position at is well formed and inside the heap
    function automatic logic size_ok(input pos_t at, input pos_t sz);
        return (sz >= TAG_P) && (sz[2:0] == 3'd0) && (sz <= HEAP_P) &&
               (at <= HEAP_P - sz);
    endfunction

endpackage

`default_nettype wire

/* rtl/bthalloc_tag_ram.sv */
// ----------------------------------------------------------------------------
// Tag RAM
// Simple dual-port synchronous RAM: one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bthalloc_tag_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 14
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/boundary_tag_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Boundary tag heap allocator
// First-fit allocate and coalescing free over an implicit block list in RAM.
// ----------------------------------------------------------------------------
// Input beat: s_axis_tuser selects allocate (0) or free (1); s_axis_tdata
// carries the request size and the payload offset to release. One result beat
// follows each input beat: m_axis_tuser is the grant flag and m_axis_tdata the
// granted payload offset (zero on failure and for every free).
// Items are handled one at a time. Allocate walks the block chain reading one
// header tag per cycle from the tag RAM until a hit or a miss. Free runs through
// the header, footer and neighbour reads and the tag writes that share the
// single RAM write port.
// After reset the block sweeps the tag RAM once, one word a cycle, and takes no
// input until the sweep is done.
// The result sits in an output register; a new input is taken while it waits,
// and the next result is held back until the receiver drains the old one.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [12:0] request_bytes, [25:13] block_offset, rest zero
    input  wire logic [bthalloc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [12:0] payload_offset, rest zero
    output logic      [bthalloc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] granted
    output logic                                     m_axis_tuser
);

    import bthalloc_pkg::*;

    state_t            state_reg, state_next;
    addr_t             clr_reg, clr_next;
    logic              m_valid_reg, m_valid_next;

    logic              op_reg, op_next;
    logic              ok_reg, ok_next;
    pos_t              at_reg, at_next;
    pos_t              sz_reg, sz_next;
    pos_t              need_reg, need_next;
    tag_t              aux_reg, aux_next;
    logic              m_user_reg, m_user_next;
    logic [OFF_W-1:0]  m_off_reg, m_off_next;

    logic              ram_we;
    addr_t             ram_waddr;
    tag_t              ram_wdata;
    logic              ram_re;
    addr_t             ram_raddr;
    tag_t              rd_tag;

    pos_t              rd_tag_p;
    pos_t              rd_sz;
    pos_t              aux_p;
    pos_t              at_sz;
    pos_t              req_need;
    pos_t              off_pos;
    logic [REQ_W-1:0]  req_in;
    logic [OFF_W-1:0]  off_in;

    bthalloc_tag_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (TAG_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_tag)
    );

    assign req_in   = s_axis_tdata[REQ_W-1:0];
    assign off_in   = s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
    assign req_need = ((POS_W'(req_in) + ALIGN_P) & ~ALIGN_P) + TAG_P;
    assign off_pos  = POS_W'(off_in);
    assign rd_tag_p = POS_W'(rd_tag);
    assign rd_sz    = rd_tag_p & ~POS_W'(1);
    assign aux_p    = POS_W'(aux_reg);
    assign at_sz    = at_reg + sz_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - OFF_W){1'b0}}, m_off_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ok_reg     <= ok_next;
        at_reg     <= at_next;
        sz_reg     <= sz_next;
        need_reg   <= need_next;
        aux_reg    <= aux_next;
        m_user_reg <= m_user_next;
        m_off_reg  <= m_off_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        op_next      = op_reg;
        ok_next      = ok_reg;
        at_next      = at_reg;
        sz_next      = sz_reg;
        need_next    = need_reg;
        aux_next     = aux_reg;
        m_user_next  = m_user_reg;
        m_off_next   = m_off_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // one free block spanning the heap, all inner words zero
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == '0 || clr_reg == LAST_A) ? HEAP_TAG : '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next = s_axis_tuser;
                    ok_next = 1'b0;
                    if (s_axis_tuser == OP_ALLOC)
                    begin
                        need_next  = req_need;
                        at_next    = '0;
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = ST_A_CHK;
                    end
                    else if (off_pos < WORD_P || off_pos[2:0] != 3'd0 ||
                             off_pos > HEAP_P)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        at_next    = off_pos - WORD_P;
                        ram_re     = 1'b1;
                        ram_raddr  = word_of(off_pos - WORD_P);
                        state_next = ST_F_HDR;
                    end
                end
            end

            ST_A_CHK:
            begin
                if (!size_ok(at_reg, rd_sz))
                begin
                    state_next = ST_RESP;
                end
                else if (!rd_tag[0] && rd_sz >= need_reg)
                begin
                    sz_next   = rd_sz;
                    ram_we    = 1'b1;
                    ram_waddr = word_of(at_reg);
                    // take the whole block when the rest could not hold two tags
                    if (rd_sz - need_reg < TAG_P)
                    begin
                        ram_wdata  = tag_of(rd_sz) | USED_TAG;
                        state_next = ST_A_WE2;
                    end
                    else
                    begin
                        ram_wdata  = tag_of(need_reg) | USED_TAG;
                        state_next = ST_A_WS2;
                    end
                end
                else if (at_reg + rd_sz >= HEAP_P)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    at_next   = at_reg + rd_sz;
                    ram_re    = 1'b1;
                    ram_raddr = word_of(at_reg + rd_sz);
                end
            end

            ST_A_WE2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_sz - WORD_P);
                ram_wdata  = tag_of(sz_reg) | USED_TAG;
                ok_next    = 1'b1;
                state_next = ST_RESP;
            end

            ST_A_WS2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_reg + need_reg - WORD_P);
                ram_wdata  = tag_of(need_reg) | USED_TAG;
                state_next = ST_A_WS3;
            end

            ST_A_WS3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_reg + need_reg);
                ram_wdata  = tag_of(sz_reg - need_reg);
                state_next = ST_A_WS4;
            end

            ST_A_WS4:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_sz - WORD_P);
                ram_wdata  = tag_of(sz_reg - need_reg);
                ok_next    = 1'b1;
                state_next = ST_RESP;
            end

            ST_F_HDR:
            begin
                if (!rd_tag[0] || !size_ok(at_reg, rd_sz))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    aux_next   = rd_tag;
                    sz_next    = rd_sz;
                    ram_re     = 1'b1;
                    ram_raddr  = word_of(at_reg + rd_sz - WORD_P);
                    state_next = ST_F_FTR;
                end
            end

            ST_F_FTR:
            begin
                if (rd_tag != aux_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = word_of(at_reg);
                    ram_wdata  = tag_of(sz_reg);
                    state_next = ST_F_W2;
                end
            end

            ST_F_W2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_sz - WORD_P);
                ram_wdata  = tag_of(sz_reg);
                state_next = ST_F_PRD;
            end

            ST_F_PRD:
            begin
                if (at_reg >= TAG_P)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = word_of(at_reg - WORD_P);
                    state_next = ST_F_PCHK;
                end
                else
                begin
                    state_next = ST_F_NRD;
                end
            end

            ST_F_PCHK:
            begin
                // previous footer must look free and point back inside the heap
                if (!rd_tag[0] && rd_tag_p >= TAG_P && rd_tag[2:0] == 3'd0 &&
                    rd_tag_p <= at_reg)
                begin
                    aux_next   = rd_tag;
                    ram_re     = 1'b1;
                    ram_raddr  = word_of(at_reg - rd_tag_p);
                    state_next = ST_F_PCMP;
                end
                else
                begin
                    state_next = ST_F_NRD;
                end
            end

            ST_F_PCMP:
            begin
                if (rd_tag == aux_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = word_of(at_reg - WORD_P);
                    ram_wdata  = '0;
                    state_next = ST_F_PW2;
                end
                else
                begin
                    state_next = ST_F_NRD;
                end
            end

            ST_F_PW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_reg);
                ram_wdata  = '0;
                at_next    = at_reg - aux_p;
                sz_next    = sz_reg + aux_p;
                state_next = ST_F_PW3;
            end

            ST_F_PW3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_reg);
                ram_wdata  = tag_of(sz_reg);
                state_next = ST_F_PW4;
            end

            ST_F_PW4:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_sz - WORD_P);
                ram_wdata  = tag_of(sz_reg);
                state_next = ST_F_NRD;
            end

            ST_F_NRD:
            begin
                if (at_sz < HEAP_P)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = word_of(at_sz);
                    state_next = ST_F_NCHK;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = ST_RESP;
                end
            end

            ST_F_NCHK:
            begin
                if (!rd_tag[0] && size_ok(at_sz, rd_tag_p))
                begin
                    aux_next   = rd_tag;
                    ram_we     = 1'b1;
                    ram_waddr  = word_of(at_sz - WORD_P);
                    ram_wdata  = '0;
                    state_next = ST_F_NW2;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = ST_RESP;
                end
            end

            ST_F_NW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_sz);
                ram_wdata  = '0;
                sz_next    = sz_reg + aux_p;
                state_next = ST_F_NW3;
            end

            ST_F_NW3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_reg);
                ram_wdata  = tag_of(sz_reg);
                state_next = ST_F_NW4;
            end

            ST_F_NW4:
            begin
                ram_we     = 1'b1;
                ram_waddr  = word_of(at_sz - WORD_P);
                ram_wdata  = tag_of(sz_reg);
                ok_next    = 1'b1;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = ok_reg;
                    m_off_next   = (ok_reg && op_reg == OP_ALLOC) ?
                                   OFF_W'(at_reg + WORD_P) : '0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bthalloc_checker.sv */
// ----------------------------------------------------------------------------
// Boundary tag heap allocator port checker
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boundary_tag_heap_allocator_unit_assert.svh"

module bthalloc_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic [bthalloc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                                s_axis_tuser,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [bthalloc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                                m_axis_tuser
);

    import bthalloc_pkg::*;

    logic in_beat;
    logic [OFF_W-1:0] out_off;

    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign out_off = m_axis_tdata[OFF_W-1:0];

    // a refused beat carries no offset
    `BTAU_ASSERT_NOW(a_fail_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, out_off == '0, "offset on refused beat")

    // payload offsets are word aligned
    `BTAU_ASSERT_NOW(a_off_align, clk, rst_n, m_axis_tvalid, out_off[2:0] == 3'd0, "unaligned payload offset")

    // one item at a time: drop ready once a beat is taken
    `BTAU_ASSERT_NEXT(a_one_item, clk, rst_n, in_beat, !s_axis_tready, "ready held after input beat")

    // a stalled result beat holds
    `BTAU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

endmodule

bind boundary_tag_heap_allocator_unit bthalloc_checker u_bthalloc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
